[sv/bpp_pkg.sv]
// shared constants, codes and helpers for the black pixel projection profile
package bpp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W   = 11;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CNT_W   = 11;
    localparam int COLOR_W = 8;
    localparam int IDX_W   = 10;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);

    typedef enum logic
    {
        CMD_PIXEL = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic
    {
        KIND_ROW    = 1'b0,
        KIND_COLUMN = 1'b1
    } kind_t;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > max_v)
            r = max_v;
        else
            r = v;
        return r;
    endfunction

endpackage

[sv/bpp_ram.sv]
// generic single write port ram with registered read
module bpp_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/black_pixel_projection_profile_top.sv]
// top level of the black pixel projection profile: row counts and column sum store
// Takes one transaction per clock, pixels in raster order or column reads, and
// sustains one item per cycle while the output is not stalled; a stalled result
// holds the whole pipeline and the input. An item passes through two register
// stages: the accepting edge updates the position counters and registers the
// column sum ram read together with the item; in the second stage the column sum
// is updated and written back, with forwarding when an item follows a pixel to the
// same column, while the result enters the output register. A row result takes
// this path once the pixel ending the row is accepted, a column total once its
// read is accepted. The column sum ram (1024 x 11, one write and one read port)
// sets the rate. A write to either dimension register restarts the frame; the
// store keeps its contents, and a column is only valid to read once a full
// frame has filled it.
module black_pixel_projection_profile_top
    import bpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [COLOR_W-1:0] red,
    input  logic [COLOR_W-1:0] green,
    input  logic [COLOR_W-1:0] blue,
    input  logic [IDX_W-1:0]   column,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [IDX_W-1:0]   index,
    output logic [CNT_W-1:0]   count,
    output logic               frame_end,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;

    logic [ADDR_W-1:0] col_pos_reg;
    logic [ADDR_W-1:0] col_pos_next;
    logic [ROW_W-1:0]  row_pos_reg;
    logic [ROW_W-1:0]  row_pos_next;
    logic [CNT_W-1:0]  row_cnt_reg;
    logic [CNT_W-1:0]  row_cnt_next;

    logic              adv;
    logic              in_accept;
    logic              cfg_write;
    logic              is_read;
    logic              black;
    logic              row_done;
    logic [CNT_W-1:0]  row_sum;

    // read-modify-write stage
    logic              s1_valid_reg;
    logic              s1_kind_reg;
    logic              s1_result_reg;
    logic [IDX_W-1:0]  s1_index_reg;
    logic [CNT_W-1:0]  s1_count_reg;
    logic              s1_frame_end_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_black_reg;
    logic              s1_first_row_reg;
    logic              s1_in_range_reg;
    logic              fwd_hit_reg;
    logic              fwd_hit_next;
    logic [CNT_W-1:0]  fwd_data_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  rd_data;
    logic [CNT_W-1:0]  prev_sum;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_data;
    logic [CNT_W-1:0]  s1_out_count;

    // output register
    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_frame_end_reg;

    assign w = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));

    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign in_accept = in_valid && adv;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign is_read  = (cmd == CMD_READ);
    assign black    = (red == '0) && (green == '0) && (blue == '0);
    assign row_sum  = row_cnt_reg + CNT_W'(black);
    assign row_done = (DIM_W'(col_pos_reg) + DIM_W'(1)) == w;
    assign rd_addr  = is_read ? ADDR_W'(column) : col_pos_reg;

    // position counters and row count
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        row_cnt_next = row_cnt_reg;
        if (in_accept && !is_read)
        begin
            if (row_done)
            begin
                col_pos_next = '0;
                row_cnt_next = '0;
                if ((DIM_W'(row_pos_reg) + DIM_W'(1)) == h)
                    row_pos_next = '0;
                else
                    row_pos_next = row_pos_reg + ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + ADDR_W'(1);
                row_cnt_next = row_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // column sum store
    bpp_ram #(
        .WIDTH(CNT_W),
        .DEPTH(MAX_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign prev_sum     = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign wr_en        = adv && s1_valid_reg && (s1_kind_reg == KIND_ROW);
    assign wr_data      = (s1_first_row_reg ? '0 : prev_sum) + CNT_W'(s1_black_reg);
    assign s1_out_count = (s1_kind_reg == KIND_COLUMN)
                          ? (s1_in_range_reg ? prev_sum : '0)
                          : s1_count_reg;
    assign fwd_hit_next = in_accept && wr_en && (s1_addr_reg == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_accept;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg      <= is_read ? KIND_COLUMN : KIND_ROW;
            s1_result_reg    <= is_read || row_done;
            s1_index_reg     <= is_read ? column : IDX_W'(row_pos_reg);
            s1_count_reg     <= row_sum;
            s1_frame_end_reg <= !is_read && ((DIM_W'(row_pos_reg) + DIM_W'(1)) == h);
            s1_addr_reg      <= rd_addr;
            s1_black_reg     <= black;
            s1_first_row_reg <= (row_pos_reg == '0);
            s1_in_range_reg  <= DIM_W'(column) < w;
            fwd_data_reg     <= wr_data;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && s1_result_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_kind_reg      <= s1_kind_reg;
            out_index_reg     <= s1_index_reg;
            out_count_reg     <= s1_out_count;
            out_frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign index     = out_index_reg;
    assign count     = out_count_reg;
    assign frame_end = out_frame_end_reg;

    // positions stay inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_pos_reg) < w)
        else $error("column position beyond width");

    assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(row_pos_reg) < h)
        else $error("row position beyond height");

    // a forwarded sum always belongs to the entry of the previous write
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg && (s1_addr_reg == $past(s1_addr_reg)))
        else $error("forwarding hit on a different column");

    // a column total is never a row result marked as frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_COLUMN) |-> !frame_end)
        else $error("frame end flagged on a column total");

endmodule

[dv/tb.sv]
// testbench for the black pixel projection profile: row counts and column totals against a predictor
module tb;
    import bpp_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 300;

    typedef struct {
        cmd_t               cmd;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [IDX_W-1:0]   column;
    } profile_item_t;

    typedef struct {
        kind_t            kind;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] count;
        logic             frame_end;
    } profile_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               cmd;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [IDX_W-1:0]   column;
    logic               out_valid;
    logic               out_stall;
    logic               kind;
    logic [IDX_W-1:0]   index;
    logic [CNT_W-1:0]   count;
    logic               frame_end;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [DIM_W-1:0]   cfg_data;

    // predictor state
    logic [DIM_W-1:0] width_setting;
    logic [DIM_W-1:0] height_setting;
    int unsigned      next_column;
    int unsigned      next_row;
    logic [CNT_W-1:0] row_blacks;
    logic [CNT_W-1:0] column_totals [MAX_WIDTH];

    profile_result_t expected_profile [$];

    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned dim_writes;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          calm;
    int          hold_req;
    int          hold_left;
    int          stall_left;

    black_pixel_projection_profile_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .column    (column),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .index     (index),
        .count     (count),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned dim_in_use(logic [DIM_W-1:0] v, int unsigned limit);
        if (v == '0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic void profile_predict(profile_item_t it);
        int unsigned      w;
        int unsigned      h;
        logic             black;
        logic [CNT_W-1:0] prev;
        profile_result_t  r;
        w = dim_in_use(width_setting, MAX_WIDTH);
        h = dim_in_use(height_setting, MAX_HEIGHT);
        if (it.cmd == CMD_READ)
        begin
            r.kind = KIND_COLUMN;
            r.index = it.column;
            r.count = (it.column < w) ? column_totals[it.column] : '0;
            r.frame_end = 1'b0;
            expected_profile.push_back(r);
            return;
        end
        black = (it.red == '0) && (it.green == '0) && (it.blue == '0);
        if (next_column >= w)
            next_column = 0;
        if (next_row >= h)
            next_row = 0;
        row_blacks = row_blacks + black;
        // first row of a frame overwrites the column total
        prev = (next_row == 0) ? '0 : column_totals[IDX_W'(next_column)];
        column_totals[IDX_W'(next_column)] = prev + black;
        next_column++;
        if (next_column < w)
            return;
        r.kind = KIND_ROW;
        r.index = IDX_W'(next_row);
        r.count = row_blacks;
        r.frame_end = (next_row + 1 == h);
        expected_profile.push_back(r);
        next_column = 0;
        row_blacks = '0;
        next_row++;
        if (next_row >= h)
            next_row = 0;
    endfunction

    function automatic profile_item_t make_pixel(int r, int g, int b);
        profile_item_t it;
        it.cmd = CMD_PIXEL;
        it.red = COLOR_W'(r);
        it.green = COLOR_W'(g);
        it.blue = COLOR_W'(b);
        it.column = IDX_W'($urandom_range(0, MAX_WIDTH - 1));
        return it;
    endfunction

    function automatic profile_item_t make_read(int c);
        profile_item_t it;
        it.cmd = CMD_READ;
        it.red = COLOR_W'($urandom_range(0, 255));
        it.green = COLOR_W'($urandom_range(0, 255));
        it.blue = COLOR_W'($urandom_range(0, 255));
        it.column = IDX_W'(c);
        return it;
    endfunction

    function automatic profile_item_t random_pixel();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return make_pixel(0, 0, 0);
        if (sel < 7)
        begin
            // a single bit set in one channel
            v = 1 << $urandom_range(0, 7);
            case ($urandom_range(0, 2))
                0:       return make_pixel(v, 0, 0);
                1:       return make_pixel(0, v, 0);
                default: return make_pixel(0, 0, v);
            endcase
        end
        return make_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    function automatic profile_item_t random_read();
        int unsigned w;
        int unsigned top;
        w = dim_in_use(width_setting, MAX_WIDTH);
        top = (w + 1 > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : w + 1;
        if ($urandom_range(0, 1) == 0)
            return make_read($urandom_range(0, MAX_WIDTH - 1));
        return make_read($urandom_range(0, top));
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                     want);
    endtask

    task automatic check_result();
        profile_result_t want;
        if (expected_profile.size() == 0)
        begin
            report_mismatch("result with nothing pending, index", index, 0);
            return;
        end
        want = expected_profile.pop_front();
        results_checked++;
        if (kind !== want.kind)
            report_mismatch("kind", kind, want.kind);
        if (index !== want.index)
            report_mismatch("index", index, want.index);
        if (count !== want.count)
            report_mismatch("count", count, want.count);
        if (frame_end !== want.frame_end)
            report_mismatch("frame_end", frame_end, want.frame_end);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
    end

    // receiver: random stalls, plus a long hold when requested
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[black_pixel_projection_profile_top] ERROR");
        $finish;
    end

    task automatic send_item(profile_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= it.cmd;
        red <= it.red;
        green <= it.green;
        blue <= it.blue;
        column <= it.column;
        do
            @(posedge clk);
        while (in_stall);
        profile_predict(it);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_profile.size() != 0)
            @(posedge clk);
        // a pixel that ends no row may still be updating the store
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dim(reg_index_t which, logic [DIM_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (which == REG_WIDTH)
            width_setting = value;
        else
            height_setting = value;
        next_column = 0;
        next_row = 0;
        row_blacks = '0;
        dim_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one all-black row at the reset dimensions: largest row count, and every column filled
    task automatic test_reset_dimensions();
        for (int i = 0; i < MAX_WIDTH; i++)
            send_item(make_pixel(0, 0, 0));
        send_item(make_read(0));
        send_item(make_read(MAX_WIDTH - 1));
        send_item(make_read(517));
    endtask

    task automatic test_dimension_limits();
        write_dim(REG_WIDTH, 11'd2047);
        write_dim(REG_HEIGHT, 11'd1025);
        send_item(make_read(MAX_WIDTH - 1));
        send_item(make_read(0));
        send_item(make_pixel(0, 0, 0));
        send_item(make_pixel(255, 255, 255));
        send_item(make_pixel(0, 0, 0));
        write_dim(REG_WIDTH, '0);
        write_dim(REG_HEIGHT, '0);
        send_item(make_pixel(0, 0, 0));
        send_item(make_pixel(255, 255, 255));
        send_item(make_pixel(0, 0, 0));
        send_item(make_pixel(0, 0, 1));
        send_item(make_read(0));
        send_item(make_read(1));
        send_item(make_read(MAX_WIDTH - 1));
        // one column over a whole frame, all black
        write_dim(REG_WIDTH, 11'd1);
        write_dim(REG_HEIGHT, 11'd64);
        repeat (64) send_item(make_pixel(0, 0, 0));
        send_item(make_read(0));
        send_item(make_read(1));
        write_dim(REG_WIDTH, 11'd1024);
        send_item(make_read(MAX_WIDTH - 1));
        send_item(make_read(0));
    endtask

    task automatic test_small_frames();
        write_dim(REG_WIDTH, 11'd3);
        write_dim(REG_HEIGHT, 11'd2);
        send_item(make_pixel(0, 0, 0));
        send_item(make_read(0));
        send_item(make_pixel(255, 255, 255));
        send_item(make_pixel(0, 0, 0));
        send_item(make_pixel(1, 0, 0));
        send_item(make_pixel(0, 0, 0));
        send_item(make_pixel(0, 128, 0));
        send_item(make_read(0));
        send_item(make_read(1));
        send_item(make_read(2));
        send_item(make_read(3));
        send_item(make_read(MAX_WIDTH - 1));
        send_item(make_pixel(0, 0, 128));
        send_item(make_pixel(0, 0, 0));
        send_item(make_read(1));
        // restart in mid row
        write_dim(REG_WIDTH, 11'd3);
        send_item(make_pixel(0, 0, 0));
        send_item(make_pixel(0, 0, 0));
        send_item(make_pixel(0, 0, 0));
        send_item(make_read(2));
    endtask

    task automatic test_backpressure();
        write_dim(REG_WIDTH, 11'd1);
        write_dim(REG_HEIGHT, 11'd3);
        calm = 1'b1;
        hold_req = 300;
        repeat (80)
            send_item(($urandom_range(0, 4) == 0) ? random_read() : random_pixel());
        calm = 1'b0;
        drain();
    endtask

    task automatic test_random();
        int unsigned target;
        int          n;
        int          r;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 19);
            w = (r == 0) ? 11'd0 : (r < 15) ? DIM_W'($urandom_range(1, 8))
                                            : DIM_W'($urandom_range(9, 40));
            r = $urandom_range(0, 19);
            h = (r == 0) ? 11'd0 : (r == 1) ? DIM_W'($urandom_range(1024, 2047))
                : (r < 15) ? DIM_W'($urandom_range(1, 6)) : DIM_W'($urandom_range(7, 20));
            case ($urandom_range(0, 5))
                0, 1, 2:
                begin
                    write_dim(REG_WIDTH, w);
                    write_dim(REG_HEIGHT, h);
                end
                3: write_dim(REG_WIDTH, w);
                4: write_dim(REG_HEIGHT, h);
                default: drain();
            endcase
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(10, 90);
            repeat (n)
                send_item(($urandom_range(0, 6) == 0) ? random_read() : random_pixel());
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_PIXEL;
        red <= '0;
        green <= '0;
        blue <= '0;
        column <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_WIDTH;
        cfg_data <= '0;
        width_setting = WIDTH_RESET;
        height_setting = HEIGHT_RESET;
        next_column = 0;
        next_row = 0;
        row_blacks = '0;
        foreach (column_totals[i])
            column_totals[i] = '0;
        items_sent = 0;
        results_checked = 0;
        dim_writes = 0;
        mismatches = 0;
        calm = 1'b0;
        hold_req = 0;
        hold_left = 0;
        stall_left = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_dimensions();
        test_dimension_limits();
        test_small_frames();
        test_backpressure();
        test_random();

        drain();
        repeat (10) @(posedge clk);
        if (expected_profile.size() != 0)
            report_mismatch("results never delivered", expected_profile.size(), 0);
        $display("%0d transactions sent, %0d results checked, %0d dimension writes",
                 items_sent, results_checked, dim_writes);
        $display("frames from 1x1 to 1024 wide and 1024 tall, reads inside and past the row");
        if (mismatches == 0)
            $display("[black_pixel_projection_profile_top] OK");
        else
            $display("[black_pixel_projection_profile_top] ERROR");
        $finish;
    end

endmodule

[files.f]
sv/bpp_pkg.sv
sv/bpp_ram.sv
sv/black_pixel_projection_profile_top.sv
dv/tb.sv
